// File: design/slrg_pkg.sv
package slrg_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned WARMUP      = 8;
  localparam int unsigned IdxW        = $clog2(TABLE_DEPTH);
  localparam int unsigned EstW        = IdxW + 1;
  localparam int unsigned CntW        = $clog2(TABLE_DEPTH + WARMUP);

  // Lehmer generator
  localparam int unsigned LehmerW = 31;
  localparam int unsigned MulW    = 15;
  localparam int unsigned ProdW   = LehmerW + MulW;

  typedef logic [LehmerW-1:0] lehmer_t;
  typedef logic [ProdW-1:0]   prod_t;

  localparam logic [MulW-1:0] LehmerMul = 15'd16807;
  localparam lehmer_t         LehmerMod = 31'h7FFF_FFFF;
  localparam lehmer_t         SampleMax = 31'd2147483389;

  // Slot divisor and its reciprocal for the index estimate
  localparam longint unsigned SlotDivL    = 64'd1 + (64'd2147483646 / TABLE_DEPTH);
  localparam lehmer_t         SlotDiv     = lehmer_t'(SlotDivL);
  localparam int unsigned     RecipShift  = 37;
  localparam longint unsigned SlotRecipL  = (64'd1 << RecipShift) / SlotDivL;
  localparam int unsigned     RecipW      = $clog2(SlotRecipL + 64'd1);
  localparam logic [RecipW-1:0] SlotRecip = RecipW'(SlotRecipL);
  localparam int unsigned     QProdW      = LehmerW + RecipW;

  // Controller to datapath commands
  typedef struct packed {
    logic load_seed;
    logic use_seed;
    logic step_mul;
    logic step_fold;
    logic seed_mode;
    logic slot_corr;
    logic slot_read;
    logic write_back;
  } slrg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic unseeded;
    logic cnt_last;
  } slrg_status_t;

  // Reduce a product modulo 2^31-1 with a Mersenne fold
  function automatic lehmer_t lehmer_fold(prod_t p);
    logic [LehmerW:0] r;
    r = {1'b0, p[LehmerW-1:0]} + (LehmerW+1)'(p[ProdW-1:LehmerW]);
    if (r >= {1'b0, LehmerMod}) begin
      r = r - {1'b0, LehmerMod};
    end
    return r[LehmerW-1:0];
  endfunction

endpackage

// File: design/slrg_if.sv
// Request channel: draw or reseed
interface slrg_req_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  slrg_pkg::lehmer_t    seed;

  modport source (output valid, output req_type, output seed, input ready);
  modport sink   (input valid, input req_type, input seed, output ready);
endinterface

// Result channel: one sample per request
interface slrg_rsp_if;
  logic                 valid;
  logic                 ready;
  slrg_pkg::lehmer_t    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: design/slrg_ctrl.sv
module slrg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_req_type_i,
  output logic                   in_ready_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  input  slrg_pkg::slrg_status_t status_i,
  output slrg_pkg::slrg_cmd_t    cmd_o
);
  import slrg_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSMul  = 3'd1;
  localparam logic [2:0] StSFold = 3'd2;
  localparam logic [2:0] StDMul  = 3'd3;
  localparam logic [2:0] StDFold = 3'd4;
  localparam logic [2:0] StDCorr = 3'd5;
  localparam logic [2:0] StDRead = 3'd6;
  localparam logic [2:0] StDWb   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Sequence seeding steps and draw stages
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_req_type_i || status_i.unseeded) begin
            cmd_o.load_seed = 1'b1;
            cmd_o.use_seed  = in_req_type_i;
            state_d         = StSMul;
          end else begin
            state_d = StDMul;
          end
        end
      end
      StSMul: begin
        cmd_o.step_mul = 1'b1;
        state_d        = StSFold;
      end
      StSFold: begin
        cmd_o.step_fold = 1'b1;
        cmd_o.seed_mode = 1'b1;
        state_d         = status_i.cnt_last ? StDMul : StSMul;
      end
      StDMul: begin
        cmd_o.step_mul = 1'b1;
        state_d        = StDFold;
      end
      StDFold: begin
        cmd_o.step_fold = 1'b1;
        state_d         = StDCorr;
      end
      StDCorr: begin
        cmd_o.slot_corr = 1'b1;
        state_d         = StDRead;
      end
      StDRead: begin
        cmd_o.slot_read = 1'b1;
        state_d         = StDWb;
      end
      StDWb: begin
        if (out_free) begin
          cmd_o.write_back = 1'b1;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.write_back) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Checks
  a_wb_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_back |=> out_valid_q)
    else $error("result not presented after write back");

  a_wb_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDWb) && out_valid_q && !out_ready_i |=> (state_q == StDWb))
    else $error("write back left while output full");

  a_seed_to_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSFold) && status_i.cnt_last |=> (state_q == StDMul))
    else $error("seeding did not hand over to the draw");

endmodule

// File: design/slrg_datapath.sv
module slrg_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slrg_pkg::lehmer_t      seed_i,
  input  slrg_pkg::slrg_cmd_t    cmd_i,
  output slrg_pkg::slrg_status_t status_o,
  output slrg_pkg::lehmer_t      sample_o
);
  import slrg_pkg::*;

  lehmer_t            lehmer_q, lehmer_d;
  lehmer_t            shuf_q, shuf_d;
  logic [CntW-1:0]    cnt_q;
  prod_t              prod_q;
  logic [QProdW-1:0]  qprod_q;
  logic [EstW-1:0]    est_q;
  logic [LehmerW:0]   back_q;
  logic [IdxW-1:0]    slot_q;
  lehmer_t            rd_q;
  lehmer_t            sample_q;
  lehmer_t            mem [TABLE_DEPTH];

  lehmer_t            seed_fix;
  lehmer_t            fold;
  logic [LehmerW:0]   diff;
  logic               corr;
  logic [EstW-1:0]    slot_wide;
  logic [IdxW-1:0]    slot;
  logic               seed_we;
  logic               we;
  logic [IdxW-1:0]    waddr;
  lehmer_t            wdata;

  // Map the seed into 1..2^31-2
  always_comb begin
    seed_fix = 31'd1;
    if (cmd_i.use_seed && (seed_i != '0) && (seed_i != LehmerMod)) begin
      seed_fix = seed_i;
    end
  end

  assign fold = lehmer_fold(prod_q);

  // Correct the slot estimate by one compare and clamp
  assign diff      = {1'b0, shuf_q} - back_q;
  assign corr      = (diff >= {1'b0, SlotDiv});
  assign slot_wide = est_q + EstW'(corr);
  always_comb begin
    slot = slot_wide[IdxW-1:0];
    if (slot_wide >= EstW'(TABLE_DEPTH)) begin
      slot = IdxW'(TABLE_DEPTH - 1);
    end
  end

  // Advance Lehmer state and shuffle output
  always_comb begin
    lehmer_d = lehmer_q;
    shuf_d   = shuf_q;
    if (cmd_i.load_seed) begin
      lehmer_d = seed_fix;
    end else if (cmd_i.step_fold) begin
      lehmer_d = fold;
    end
    if (cmd_i.step_fold && cmd_i.seed_mode && (cnt_q == '0)) begin
      shuf_d = fold;
    end else if (cmd_i.write_back) begin
      shuf_d = rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lehmer_q <= '0;
      shuf_q   <= '0;
    end else begin
      lehmer_q <= lehmer_d;
      shuf_q   <= shuf_d;
    end
  end

  // Step counter, products and slot pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      cnt_q <= CntW'(TABLE_DEPTH + WARMUP - 1);
    end else if (cmd_i.step_fold && cmd_i.seed_mode && (cnt_q != '0)) begin
      cnt_q <= cnt_q - CntW'(1);
    end
    if (cmd_i.step_mul) begin
      prod_q  <= {{MulW{1'b0}}, lehmer_q} * ProdW'(LehmerMul);
      qprod_q <= {{RecipW{1'b0}}, shuf_q} * QProdW'(SlotRecip);
    end
    if (cmd_i.step_fold) begin
      est_q <= EstW'(qprod_q >> RecipShift);
    end
    if (cmd_i.slot_corr) begin
      back_q <= {1'b0, SlotDiv} * (LehmerW+1)'(est_q);
    end
    if (cmd_i.write_back) begin
      sample_q <= (rd_q > SampleMax) ? SampleMax : rd_q;
    end
  end

  // Table write port: seeding fill or draw refill
  assign seed_we = cmd_i.step_fold && cmd_i.seed_mode && (cnt_q < CntW'(TABLE_DEPTH));
  assign we      = seed_we || cmd_i.write_back;
  assign waddr   = seed_we ? cnt_q[IdxW-1:0] : slot_q;
  assign wdata   = seed_we ? fold : lehmer_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.slot_read) begin
      rd_q   <= mem[slot];
      slot_q <= slot;
    end
  end

  assign status_o.unseeded = (shuf_q == '0);
  assign status_o.cnt_last = (cnt_q == '0);
  assign sample_o          = sample_q;

  // Checks
  a_fold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_fold |=> (lehmer_q != '0) && (lehmer_q != LehmerMod))
    else $error("Lehmer state left its range");

  a_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_fold && cmd_i.seed_mode && (cnt_q == '0) |=> (shuf_q != '0))
    else $error("seeding left the generator unseeded");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slot_read |-> (slot_wide < EstW'(TABLE_DEPTH)))
    else $error("slot estimate out of table range");

endmodule

// File: design/shuffled_lehmer_random_generator_core.sv
// Channel  | Direction | Payload              | Transfer
// req_i    | in        | req_type, seed       | valid && ready
// rsp_o    | out       | sample               | valid && ready
//
// A draw runs one Lehmer step split into a 31x15 multiply and a Mersenne fold,
// a slot estimate with one correction multiply, and a registered table read
// before write back; its sample is presented in the same cycle that the next
// request can be taken.
// A reseed, or a draw while unseeded, first runs 40 Lehmer steps.
// Reset clears the generator to the unseeded state; the table holds no reset.
// A new request is taken while a sample still waits; write back stalls while
// the output register is full.
module shuffled_lehmer_random_generator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  slrg_req_if.sink  req_i,
  slrg_rsp_if.source rsp_o
);
  import slrg_pkg::*;

  slrg_cmd_t    cmd;
  slrg_status_t status;

  // Sequence control
  slrg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_req_type_i (req_i.req_type),
    .in_ready_o    (req_i.ready),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Generator state, shuffle table and sample register
  slrg_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .seed_i   (req_i.seed),
    .cmd_i    (cmd),
    .status_o (status),
    .sample_o (rsp_o.sample)
  );

endmodule
